[design/ccd_pkg.sv]
// shared types, constants and the coin value table for the coin change dispenser
`timescale 1ns / 1ps

package ccd_pkg;

  localparam int NUM_DENOMS   = 8;
  localparam int CODED_DENOMS = 8;
  localparam int LIVE_DENOMS  = (NUM_DENOMS < CODED_DENOMS) ? NUM_DENOMS : CODED_DENOMS;
  localparam int IDX_W        = $clog2(CODED_DENOMS);
  localparam int PRICE_W      = 16;
  localparam int PAID_W       = 17;
  localparam int COUNT_W      = 16;
  localparam int TALLY_W      = 8;
  localparam int VALUE_W      = 11;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_INSERT = 2'd1,
    OP_CANCEL = 2'd2,
    OP_RESET  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_OWED     = 3'd0,
    K_CHANGE   = 3'd1,
    K_DONE     = 3'd2,
    K_NOCHANGE = 3'd3,
    K_CANCEL   = 3'd4,
    K_REJECT   = 3'd5,
    K_RESET    = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAYCHK,
    S_CHANGE,
    S_GREEDY,
    S_CHECK,
    S_UPDATE,
    S_DONE
  } state_t;

  // status of the shared subtract and compare unit
  typedef struct packed {
    logic [PAID_W-1:0] diff;
    logic              borrow;
    logic              zero;
  } sub_res_t;

  // coin values in cents, code 0 is the smallest
  function automatic logic [VALUE_W-1:0] coin_value(input logic [IDX_W-1:0] code);
    logic [VALUE_W-1:0] v;
    case (code)
      3'd0:    v = 11'd5;
      3'd1:    v = 11'd10;
      3'd2:    v = 11'd20;
      3'd3:    v = 11'd50;
      3'd4:    v = 11'd100;
      3'd5:    v = 11'd200;
      3'd6:    v = 11'd500;
      3'd7:    v = 11'd1000;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

endpackage

[design/coin_change_dispenser.sv]
// top level of the coin change dispenser: sequencer, coin inventory and output register
//
// input beats arrive on s_tvalid/s_tready: s_tuser is the operation (start, insert,
// cancel, reset coins), s_tdata carries the price and the coin code. results leave on
// m_tvalid/m_tready: m_tuser is the result kind, m_tlast marks the final beat of the
// results caused by one input. cfg_we with cfg_data loads the default coin count
// used by a reset coins operation; the user must write it only while the block is
// idle, and the block itself does not enforce this. cancel, reset coins, refused
// inserts and a priced start give one beat straight from idle; an insert that leaves
// money owed gives its beat from the payment check. a completing insert runs the
// greedy walk on one shared subtractor: the payment check and the change setup, a
// walk from the largest denomination down taking a coin while one fits and is on hand,
// a check of the remainder, a pass over the denominations to update stock and emit
// change records, then the done beat; a no change beat comes from the remainder
// check, and a free start enters at the change setup and gives its done beat.
// s_tready is high only while the sequencer is idle and the output register is free
// or being emptied, so one item is worked on at a time.
// a stalled receiver holds the output register and the sequencer waits in place.
// reset (rst, synchronous) clears the session, the coin stock and the output
// register, and sets the default coin count to 20.

module coin_change_dispenser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // price_cents[15:0], coin_code[18:16], zero fill
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // coin_code_res[2:0], coin_count[10:3], amount_owed[26:11]
  output logic [2:0]  m_tuser,   // kind[2:0]
  output logic        m_tlast
);
  import ccd_pkg::*;

  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(LIVE_DENOMS - 1);

  state_t state, state_next;

  logic [COUNT_W-1:0] def_count;
  logic [COUNT_W-1:0] stock [CODED_DENOMS];
  logic [TALLY_W-1:0] tally [CODED_DENOMS];
  logic [TALLY_W-1:0] take  [CODED_DENOMS];
  logic [PAID_W-1:0]  paid;
  logic [PRICE_W-1:0] price;
  logic               active;
  logic [PRICE_W-1:0] rest;
  logic [PRICE_W-1:0] change;
  logic [IDX_W-1:0]   idx;

  // output register
  kind_t              out_kind;
  logic [IDX_W-1:0]   out_code;
  logic [TALLY_W-1:0] out_count;
  logic [PRICE_W-1:0] out_amount;
  logic               out_last;

  // beat to load into the output register
  logic               emit;
  kind_t              e_kind;
  logic [IDX_W-1:0]   e_code;
  logic [TALLY_W-1:0] e_count;
  logic [PRICE_W-1:0] e_amount;
  logic               e_last;

  op_t                in_op;
  logic [PRICE_W-1:0] in_price;
  logic [IDX_W-1:0]   in_code;
  logic               s_fire;
  logic               out_free;
  logic               bad_coin;
  logic [IDX_W-1:0]   rd_idx;
  logic [TALLY_W-1:0] tally_rd;
  logic [COUNT_W:0]   avail;
  logic [COUNT_W-1:0] sat_sum;
  logic               step_ok;
  logic               end_sess;

  logic [PAID_W-1:0]  sub_a, sub_b;
  sub_res_t           sub;

  assign in_op    = op_t'(s_tuser);
  assign in_price = s_tdata[15:0];
  assign in_code  = s_tdata[16 +: IDX_W];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign s_fire   = s_tvalid && s_tready;

  // tally is read at the coin code while idle and at the walk index otherwise
  assign rd_idx   = (state == S_IDLE) ? in_code : idx;
  assign tally_rd = tally[rd_idx];
  assign bad_coin = ({1'b0, in_code} >= (IDX_W + 1)'(LIVE_DENOMS)) || (tally_rd == '1);

  // coins on hand for the denomination under the walk index
  assign avail   = {1'b0, stock[idx]} + {{(COUNT_W - TALLY_W + 1){1'b0}}, tally_rd};
  assign sat_sum = avail[COUNT_W] ? '1 : avail[COUNT_W-1:0];

  always_comb begin
    case (state)
      S_CHANGE: begin
        sub_a = paid;
        sub_b = {1'b0, price};
      end
      S_GREEDY: begin
        sub_a = {1'b0, rest};
        sub_b = {(PAID_W - VALUE_W)'(0), coin_value(idx)};
      end
      default: begin
        sub_a = {1'b0, price};
        sub_b = paid;
      end
    endcase
  end

  ccd_sub_unit u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub)
  );

  assign step_ok = !sub.borrow && ({{(COUNT_W - TALLY_W + 1){1'b0}}, take[idx]} < avail);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    e_kind     = K_OWED;
    e_code     = '0;
    e_count    = '0;
    e_amount   = '0;
    e_last     = 1'b1;
    end_sess   = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          case (in_op)
            OP_START: begin
              if (in_price == '0) begin
                state_next = S_CHANGE;
              end else begin
                emit     = 1'b1;
                e_kind   = K_OWED;
                e_amount = in_price;
              end
            end
            OP_INSERT: begin
              if (!active) begin
                emit   = 1'b1;
                e_kind = K_REJECT;
              end else if (bad_coin) begin
                emit     = 1'b1;
                e_kind   = K_REJECT;
                e_amount = sub.diff[PRICE_W-1:0];
              end else begin
                state_next = S_PAYCHK;
              end
            end
            OP_CANCEL: begin
              emit = 1'b1;
              if (!active) begin
                e_kind = K_REJECT;
              end else begin
                e_kind   = K_CANCEL;
                e_amount = paid[PRICE_W-1:0];
                end_sess = 1'b1;
              end
            end
            OP_RESET: begin
              emit   = 1'b1;
              e_kind = K_RESET;
            end
            default: begin
              emit   = 1'b1;
              e_kind = K_REJECT;
            end
          endcase
        end
      end
      S_PAYCHK: begin
        // price minus paid: no borrow and nonzero means money is still owed
        if (sub.borrow || sub.zero) begin
          state_next = S_CHANGE;
        end else if (out_free) begin
          emit       = 1'b1;
          e_kind     = K_OWED;
          e_amount   = sub.diff[PRICE_W-1:0];
          state_next = S_IDLE;
        end
      end
      S_CHANGE: begin
        state_next = S_GREEDY;
      end
      S_GREEDY: begin
        if (!step_ok && idx == '0) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (rest == '0) begin
          state_next = S_UPDATE;
        end else if (out_free) begin
          emit       = 1'b1;
          e_kind     = K_NOCHANGE;
          e_amount   = change;
          end_sess   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_UPDATE: begin
        if (take[idx] == '0 || out_free) begin
          if (take[idx] != '0) begin
            emit    = 1'b1;
            e_kind  = K_CHANGE;
            e_code  = idx;
            e_count = take[idx];
            e_last  = 1'b0;
          end
          if (idx == '0) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = K_DONE;
          e_amount   = change;
          end_sess   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // session and inventory datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      def_count <= 16'd20;
      paid      <= '0;
      price     <= '0;
      active    <= 1'b0;
      for (int i = 0; i < CODED_DENOMS; i++) begin
        stock[i] <= '0;
        tally[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        def_count <= cfg_data;
      end
      if (end_sess) begin
        paid   <= '0;
        active <= 1'b0;
        for (int i = 0; i < CODED_DENOMS; i++) begin
          tally[i] <= '0;
        end
      end
      if (state == S_IDLE && s_fire) begin
        case (in_op)
          OP_START: begin
            price  <= in_price;
            paid   <= '0;
            active <= 1'b1;
            for (int i = 0; i < CODED_DENOMS; i++) begin
              tally[i] <= '0;
            end
          end
          OP_INSERT: begin
            if (active && !bad_coin) begin
              tally[in_code] <= tally_rd + 1'b1;
              paid           <= paid + {(PAID_W - VALUE_W)'(0), coin_value(in_code)};
            end
          end
          OP_RESET: begin
            for (int i = 0; i < CODED_DENOMS; i++) begin
              stock[i] <= def_count;
            end
          end
          default: begin
          end
        endcase
      end
      if (state == S_UPDATE && (take[idx] == '0 || out_free)) begin
        stock[idx] <= sat_sum - {(COUNT_W - TALLY_W)'(0), take[idx]};
      end
    end
  end

  // greedy walk registers
  always_ff @(posedge clk) begin
    case (state)
      S_CHANGE: begin
        rest   <= sub.diff[PRICE_W-1:0];
        change <= sub.diff[PRICE_W-1:0];
        idx    <= TOP_IDX;
        for (int i = 0; i < CODED_DENOMS; i++) begin
          take[i] <= '0;
        end
      end
      S_GREEDY: begin
        if (step_ok) begin
          rest      <= sub.diff[PRICE_W-1:0];
          take[idx] <= take[idx] + 1'b1;
        end else if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
      S_CHECK: begin
        idx <= TOP_IDX;
      end
      S_UPDATE: begin
        if ((take[idx] == '0 || out_free) && idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register, loaded only when it is free or being emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= e_kind;
      out_code   <= e_code;
      out_count  <= e_count;
      out_amount <= e_amount;
      out_last   <= e_last;
    end
  end

  assign m_tdata = {5'b0, out_amount, out_count, out_code};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

[design/ccd_sub_unit.sv]
// shared subtract and compare unit used by the sequencer for the refused insert amount, payment check and greedy walk
`timescale 1ns / 1ps

module ccd_sub_unit (
  input  logic [ccd_pkg::PAID_W-1:0] a,
  input  logic [ccd_pkg::PAID_W-1:0] b,
  output ccd_pkg::sub_res_t          res
);
  import ccd_pkg::*;

  logic [PAID_W:0] wide;

  assign wide       = {1'b0, a} - {1'b0, b};
  assign res.diff   = wide[PAID_W-1:0];
  assign res.borrow = wide[PAID_W];
  assign res.zero   = (wide == '0);

endmodule

[dv/testbench.sv]
// self-checking testbench for the coin change dispenser
`timescale 1ns / 1ps

module testbench;
  import ccd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 240;
  localparam int PHASE_ITEMS    = 14;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  code;
    logic [7:0]  count;
    logic [15:0] amount;
    logic        last;
  } beat_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] price;
    logic [2:0]  code;
    logic        typed;
    kind_t       kind;
    logic [15:0] amount;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // price_cents[15:0], coin_code[18:16], zero fill
  logic [1:0]  s_tuser = '0;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // coin_code_res[2:0], coin_count[10:3], amount_owed[26:11]
  logic [2:0]  m_tuser;        // kind[2:0]
  logic        m_tlast;

  // typed expectation riding along with a directed beat
  logic        hint_on = 1'b0;
  kind_t       hint_kind = K_OWED;
  logic [15:0] hint_amount = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int faults = 0;
  int items_sent = 0;
  int items_taken = 0;
  int beats_seen = 0;
  int sales = 0;
  int refusals = 0;
  int quiet_cycles = 0;

  // mirror of the dispenser state
  int unsigned coin_cents [0:7] = '{5, 10, 20, 50, 100, 200, 500, 1000};
  logic [15:0] stock [0:7];
  logic [7:0]  tally [0:7];
  logic [16:0] paid;
  logic [15:0] price_held;
  logic        active;
  logic [15:0] refill_count;
  beat_t       due_beats [$];

  // directed beats; kind and amount are given where the single result is obvious
  row_t plan [0:25] = '{
    '{OP_INSERT, 16'd0,     3'd0, 1'b1, K_REJECT,   16'd0},
    '{OP_CANCEL, 16'hffff,  3'd7, 1'b1, K_REJECT,   16'd0},
    '{OP_START,  16'd5,     3'd0, 1'b1, K_OWED,     16'd5},
    '{OP_INSERT, 16'd0,     3'd1, 1'b1, K_NOCHANGE, 16'd5},     // empty stock
    '{OP_START,  16'd0,     3'd0, 1'b1, K_DONE,     16'd0},     // free item
    '{OP_RESET,  16'd0,     3'd0, 1'b1, K_RESET,    16'd0},
    '{OP_START,  16'hffff,  3'd0, 1'b1, K_OWED,     16'hffff},
    '{OP_INSERT, 16'd0,     3'd7, 1'b1, K_OWED,     16'd64535},
    '{OP_START,  16'd350,   3'd0, 1'b1, K_OWED,     16'd350},   // drops open session
    '{OP_CANCEL, 16'd0,     3'd0, 1'b1, K_CANCEL,   16'd0},
    '{OP_START,  16'd350,   3'd0, 1'b1, K_OWED,     16'd350},
    '{OP_INSERT, 16'd0,     3'd6, 1'b0, K_OWED,     16'd0},
    '{OP_START,  16'd135,   3'd0, 1'b1, K_OWED,     16'd135},
    '{OP_INSERT, 16'd0,     3'd0, 1'b1, K_OWED,     16'd130},
    '{OP_INSERT, 16'd0,     3'd2, 1'b1, K_OWED,     16'd110},
    '{OP_CANCEL, 16'd0,     3'd0, 1'b1, K_CANCEL,   16'd25},
    '{OP_START,  16'd1,     3'd0, 1'b1, K_OWED,     16'd1},
    '{OP_INSERT, 16'd0,     3'd7, 1'b1, K_NOCHANGE, 16'd999},   // change not a multiple of 5c
    '{OP_START,  16'd5,     3'd0, 1'b1, K_OWED,     16'd5},
    '{OP_INSERT, 16'd0,     3'd0, 1'b1, K_DONE,     16'd0},
    '{OP_START,  16'd15,    3'd0, 1'b1, K_OWED,     16'd15},
    '{OP_INSERT, 16'd0,     3'd7, 1'b0, K_OWED,     16'd0},
    '{OP_INSERT, 16'd0,     3'd5, 1'b1, K_REJECT,   16'd0},
    '{OP_START,  16'd100,   3'd0, 1'b1, K_OWED,     16'd100},
    '{OP_INSERT, 16'd0,     3'd3, 1'b1, K_OWED,     16'd50},
    '{OP_INSERT, 16'd0,     3'd4, 1'b0, K_OWED,     16'd0}
  };

  coin_change_dispenser dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void push_beat(kind_t k, logic [2:0] c, logic [7:0] n, logic [15:0] amt);
    beat_t b;
    b = '{k, c, n, amt, 1'b0};
    due_beats = {due_beats, b};
  endfunction

  function automatic void close_session();
    for (int i = 0; i < 8; i++) tally[i] = '0;
    paid = '0;
    active = 1'b0;
  endfunction

  // greedy change from the largest coin down, stock plus this session's coins
  function automatic void settle_purchase();
    int unsigned change, rest, avail, sum;
    int unsigned take [0:7];
    change = paid - price_held;
    rest = change;
    for (int i = LIVE_DENOMS - 1; i >= 0; i--) begin
      avail = stock[i];
      avail += tally[i];
      take[i] = rest / coin_cents[i];
      if (take[i] > avail) take[i] = avail;
      rest -= take[i] * coin_cents[i];
    end
    if (rest != 0) begin
      push_beat(K_NOCHANGE, 3'd0, 8'd0, 16'(change));
    end else begin
      for (int i = LIVE_DENOMS - 1; i >= 0; i--) begin
        sum = stock[i];
        sum += tally[i];
        // inserted coins saturate the stock before the change leaves
        if (sum > 32'hffff) sum = 32'hffff;
        stock[i] = 16'(sum - take[i]);
        if (take[i] != 0) push_beat(K_CHANGE, 3'(i), 8'(take[i]), 16'd0);
      end
      push_beat(K_DONE, 3'd0, 8'd0, 16'(change));
    end
    close_session();
  endfunction

  function automatic void dispense_step(op_t op, logic [15:0] price, logic [2:0] code);
    beat_t b;
    case (op)
      OP_START: begin
        close_session();
        price_held = price;
        active = 1'b1;
        if (price == 16'd0) settle_purchase();
        else push_beat(K_OWED, 3'd0, 8'd0, price);
      end
      OP_INSERT: begin
        if (!active) begin
          push_beat(K_REJECT, 3'd0, 8'd0, 16'd0);
        end else if (code >= LIVE_DENOMS || tally[code] == 8'hff) begin
          push_beat(K_REJECT, 3'd0, 8'd0, 16'(price_held - paid));
        end else begin
          tally[code] = tally[code] + 8'd1;
          paid = paid + 17'(coin_cents[code]);
          if (paid < price_held) push_beat(K_OWED, 3'd0, 8'd0, 16'(price_held - paid));
          else settle_purchase();
        end
      end
      OP_CANCEL: begin
        if (!active) begin
          push_beat(K_REJECT, 3'd0, 8'd0, 16'd0);
        end else begin
          push_beat(K_CANCEL, 3'd0, 8'd0, paid[15:0]);
          close_session();
        end
      end
      default: begin
        for (int i = 0; i < 8; i++) stock[i] = refill_count;
        push_beat(K_RESET, 3'd0, 8'd0, 16'd0);
      end
    endcase
    b = due_beats.pop_back();
    b.last = 1'b1;
    due_beats = {due_beats, b};
  endfunction

  function automatic void compare_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, label, want, got);
      faults++;
    end
  endfunction

  // accepted input beats and register writes update the mirror
  always @(posedge clk) begin : intake
    int    held_n;
    beat_t b;
    if (rst) begin
      for (int i = 0; i < 8; i++) stock[i] = '0;
      close_session();
      price_held = '0;
      refill_count = 16'd20;
    end else begin
      if (cfg_we) refill_count = cfg_data;
      if (s_tvalid && s_tready) begin
        held_n = due_beats.size();
        dispense_step(op_t'(s_tuser), s_tdata[15:0], s_tdata[18:16]);
        if (hint_on) begin
          while (due_beats.size() > held_n) b = due_beats.pop_back();
          b = '{hint_kind, 3'd0, 8'd0, hint_amount, 1'b1};
          due_beats = {due_beats, b};
        end
        items_taken++;
      end
    end
  end

  always @(posedge clk) begin : outlet
    beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      if (due_beats.size() == 0) begin
        $display("%0t: result beat with none due: kind %0d code %0d count %0d amount %0d last %0b",
                 $time, m_tuser, m_tdata[2:0], m_tdata[10:3], m_tdata[26:11], m_tlast);
        faults++;
      end else begin
        want = due_beats.pop_front();
        if (want.kind == K_DONE) sales++;
        if (want.kind == K_NOCHANGE) refusals++;
        compare_field("kind", want.kind, m_tuser);
        compare_field("coin_code_res", want.code, m_tdata[2:0]);
        compare_field("coin_count", want.count, m_tdata[10:3]);
        compare_field("amount_owed", want.amount, m_tdata[26:11]);
        compare_field("last", want.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** coin_change_dispenser: FAILED **");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that took the beat
  task automatic send_item(input op_t op, input logic [15:0] price, input logic [2:0] code,
                           input logic typed, input kind_t k, input logic [15:0] amt);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid    <= 1'b1;
    s_tuser     <= op;
    s_tdata     <= {5'd0, code, price};
    hint_on     <= typed;
    hint_kind   <= k;
    hint_amount <= amt;
    items_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_plain(input op_t op, input logic [15:0] price, input logic [2:0] code);
    send_item(op, price, code, 1'b0, K_OWED, 16'd0);
  endtask

  // hold the sender until every due result is out and the sequencer is back at rest
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_refill(input logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // mostly whole purchases with random coins, some refills and noise
  task automatic run_session();
    int          pick, left, coins;
    logic [15:0] p;
    logic [2:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_plain(OP_RESET, 16'($urandom), 3'($urandom));
    end else if (pick < 14) begin
      send_plain(op_t'($urandom_range(0, 3)), 16'($urandom), 3'($urandom));
    end else begin
      case ($urandom_range(0, 5))
        0:       p = 16'($urandom);
        1:       p = 16'($urandom_range(0, 9));
        default: p = 16'(5 * $urandom_range(1, 80));
      endcase
      send_plain(OP_START, p, 3'($urandom));
      left = p;
      coins = 0;
      while (left > 0 && coins < 8) begin
        if ($urandom_range(0, 24) == 0) begin
          send_plain(OP_CANCEL, 16'($urandom), 3'($urandom));
          left = 0;
        end else begin
          c = 3'($urandom_range(0, 7));
          send_plain(OP_INSERT, 16'($urandom), c);
          left -= coin_cents[c];
          coins++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] refill_plan [0:5];
    int          first;
    refill_plan = '{16'hffff, 16'd0, 16'd2, 16'($urandom_range(1, 400)), 16'd20, 16'd500};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 13;
    recv_stall_pct = 13;
    foreach (plan[i])
      send_item(plan[i].op, plan[i].price, plan[i].code, plan[i].typed, plan[i].kind,
                plan[i].amount);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      load_refill(refill_plan[ph]);
      send_plain(OP_RESET, 16'($urandom), 3'($urandom));
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) begin
        run_session();
        if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_beats.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_beats.size());
      faults++;
    end
    $display("run covered %0d input beats under four pacing modes and six refill counts;",
             items_taken);
    $display("%0d result beats checked, %0d sales completed, %0d refused for lack of change",
             beats_seen, sales, refusals);
    if (faults == 0) begin
      $display("** coin_change_dispenser: PASSED **");
    end else begin
      $display("** coin_change_dispenser: FAILED **");
    end
    $finish;
  end

endmodule
